[design/tsrd_pkg.sv]
// Shared types and constants of the distance-sensor bus target.
// Register map, item kinds and store sizing; no dependencies.

package tsrd_pkg;

    // byte store sizing
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // ranging period: (period byte + 1) * ticks per unit
    localparam int TICKS_PER_PERIOD_UNIT = 10;
    localparam int PERIOD_W              = $clog2(256 * TICKS_PER_PERIOD_UNIT + 1);

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_CONNECT = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // register map
    localparam logic [15:0] ADDR_ID           = 16'h0000;
    localparam logic [15:0] ADDR_INT_CLEAR    = 16'h0015;
    localparam logic [15:0] ADDR_FRESH        = 16'h0016;
    localparam logic [15:0] ADDR_RANGE_START  = 16'h0018;
    localparam logic [15:0] ADDR_THRESH_LOW   = 16'h001A;
    localparam logic [15:0] ADDR_PERIOD       = 16'h001B;
    localparam logic [15:0] ADDR_RANGE_STATUS = 16'h004D;
    localparam logic [15:0] ADDR_INT_STATUS   = 16'h004F;
    localparam logic [15:0] ADDR_RANGE_VAL    = 16'h0062;
    localparam logic [15:0] ADDR_RETURN_RATE  = 16'h0066;

    // fixed read-only values
    localparam logic [7:0] ID_VALUE          = 8'hB4;
    localparam logic [7:0] INT_STATUS_VALUE  = 8'h04;
    localparam logic [7:0] RETURN_RATE_VALUE = 8'h10;
    localparam logic [7:0] DIST_SAT          = 8'hFF;
    localparam logic [7:0] FRESH_RESET       = 8'h01;

    // continuous-mode bit of the range start register
    localparam int RANGE_CONT_BIT = 1;

endpackage

[design/tsrd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.

module tsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/tof_sensor_register_device_unit.sv]
// Top level of the distance-sensor bus target, register level.
// Uses tsrd_pkg and the byte store RAM tsrd_ram.
//
// Usage:
//   Input items arrive on the s_ channel, one bus event per transaction:
//   connect, written byte, read request or one-millisecond tick, each with
//   the present distance, error code and unplugged flag. Every item gives
//   exactly one result on the m_ channel: ack, read byte, interrupt level.
//   An item moves from the input register to the result register, and
//   m_tvalid rises once the result register holds it; the item waits in the
//   input register while a held result blocks it. Throughput is one item
//   per cycle while m_tready stays high; the input register is refilled in
//   the same cycle that its item moves to the result register.
//   The byte store RAM is read ahead at the pointer value that
//   the current item leaves behind, so a read item finds its data ready.
//   Per-entry valid bits make unwritten store entries read as zero, so no
//   clearing pass is needed after reset.
//   Reset (aresetn low, synchronous) empties both registers, zeroes the
//   pointer, interrupt latch and ranging state, and sets the fresh flag.
//   When the receiver holds m_tready low, the result stays put and one
//   more item can wait in the input register before s_tready drops.

module tof_sensor_register_device_unit
    import tsrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], distance_mm[23:8],
                                   // range_error[27:24], unplugged[28], zero[31:29]
    input  logic [2:0]  s_tuser,   // operation[1:0], is_read[2]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ack[0], read_data[8:1], interrupt_pin[9],
                                   // zero[15:10]
);

    // input register
    logic        in_valid_reg, in_valid_next;
    op_t         op_reg;
    logic        is_read_reg;
    logic [7:0]  data_reg;
    logic [15:0] dist_reg;
    logic [3:0]  err_reg;
    logic        unpl_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        out_ack_reg, out_ack_next;
    logic [7:0]  out_rd_reg, out_rd_next;
    logic        out_irq_reg;

    // device state
    logic [15:0]         ptr_reg, ptr_next;
    logic [1:0]          seen_reg, seen_next;
    logic [7:0]          fresh_reg, fresh_next;
    logic                latch_reg, latch_next;
    logic                running_reg, running_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [7:0]          start_reg, start_next;     // copy of store entry 0x018
    logic [7:0]          thresh_reg, thresh_next;   // copy of store entry 0x01A
    logic [7:0]          per_byte_reg, per_byte_next; // copy of store entry 0x01B
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;

    // datapath helpers
    logic                fire;
    logic                in_take;
    logic [7:0]          sat_dist;
    logic                ptr_in_store;
    logic [7:0]          store_byte;
    logic [7:0]          ram_q;
    logic                wr_en;
    logic                eval;
    logic                latch_clear;
    logic                near;
    logic [PERIOD_W-1:0] tick_inc;
    logic [PERIOD_W-1:0] period_calc;
    logic [7:0]          read_mux;

    // handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_irq_reg, out_rd_reg, out_ack_reg};

    // saturated distance and store lookup
    assign sat_dist     = (|dist_reg[15:8]) ? DIST_SAT : dist_reg[7:0];
    assign ptr_in_store = ptr_reg < 16'(STORE_DEPTH);
    assign store_byte   = (ptr_in_store && valid_reg[ptr_reg[STORE_AW-1:0]]) ? ram_q : 8'h00;
    assign tick_inc     = tick_reg + 1'b1;
    assign period_calc  = PERIOD_W'(({1'b0, per_byte_reg} + 9'd1) * TICKS_PER_PERIOD_UNIT);

    // read map
    always_comb begin
        unique case (ptr_reg)
            ADDR_ID:           read_mux = ID_VALUE;
            ADDR_FRESH:        read_mux = fresh_reg;
            ADDR_INT_STATUS:   read_mux = INT_STATUS_VALUE;
            ADDR_RANGE_STATUS: read_mux = {err_reg, 4'h0};
            ADDR_RANGE_VAL:    read_mux = sat_dist;
            ADDR_RETURN_RATE:  read_mux = RETURN_RATE_VALUE;
            default:           read_mux = store_byte;
        endcase
    end

    // item processing
    always_comb begin
        ptr_next      = ptr_reg;
        seen_next     = seen_reg;
        fresh_next    = fresh_reg;
        running_next  = running_reg;
        tick_next     = tick_reg;
        period_next   = period_reg;
        start_next    = start_reg;
        thresh_next   = thresh_reg;
        per_byte_next = per_byte_reg;
        valid_next    = valid_reg;
        wr_en         = 1'b0;
        eval          = 1'b0;
        latch_clear   = 1'b0;
        out_ack_next  = 1'b1;
        out_rd_next   = 8'h00;

        if (fire) begin
            unique case (op_reg)
                OP_CONNECT: begin
                    if (unpl_reg) begin
                        out_ack_next = 1'b0;
                    end else if (!is_read_reg) begin
                        seen_next = 2'd0;
                    end
                end
                OP_WRITE: begin
                    if (seen_reg == 2'd0) begin
                        ptr_next  = {data_reg, 8'h00};
                        seen_next = 2'd1;
                    end else if (seen_reg == 2'd1) begin
                        ptr_next  = ptr_reg | {8'h00, data_reg};
                        seen_next = 2'd2;
                    end else begin
                        // register write and its side effects
                        if (ptr_reg == ADDR_FRESH) begin
                            fresh_next = data_reg;
                        end
                        if (ptr_reg == ADDR_INT_CLEAR) begin
                            latch_clear = 1'b1;
                        end
                        if (ptr_in_store) begin
                            wr_en = 1'b1;
                            valid_next[ptr_reg[STORE_AW-1:0]] = 1'b1;
                        end
                        if (ptr_reg == ADDR_THRESH_LOW) begin
                            thresh_next = data_reg;
                        end
                        if (ptr_reg == ADDR_PERIOD) begin
                            per_byte_next = data_reg;
                        end
                        if (ptr_reg == ADDR_RANGE_START) begin
                            start_next = data_reg;
                            if (data_reg[RANGE_CONT_BIT]) begin
                                period_next  = period_calc;
                                tick_next    = '0;
                                running_next = 1'b1;
                            end else begin
                                running_next = 1'b0;
                            end
                        end
                        ptr_next = ptr_reg + 16'd1;
                        eval     = 1'b1;
                    end
                end
                OP_READ: begin
                    out_rd_next = read_mux;
                    ptr_next    = ptr_reg + 16'd1;
                    eval        = 1'b1;
                end
                OP_TICK: begin
                    if (running_reg) begin
                        if (tick_inc >= period_reg) begin
                            tick_next = '0;
                            eval      = 1'b1;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // interrupt latch: clear first, then a near target sets it
    assign near       = (thresh_next != 8'h00) && (sat_dist < thresh_next);
    assign latch_next = (latch_reg && !latch_clear) ||
                        (eval && start_next[RANGE_CONT_BIT] && near);

    // register valid flags
    assign in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // byte store, read ahead at the next pointer
    tsrd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ptr_reg[STORE_AW-1:0]),
        .wdata (data_reg),
        .raddr (ptr_next[STORE_AW-1:0]),
        .rdata (ram_q)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            fresh_reg     <= FRESH_RESET;
            latch_reg     <= 1'b0;
            running_reg   <= 1'b0;
            tick_reg      <= '0;
            period_reg    <= '0;
            start_reg     <= '0;
            thresh_reg    <= '0;
            per_byte_reg  <= '0;
            valid_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            ptr_reg       <= ptr_next;
            seen_reg      <= seen_next;
            fresh_reg     <= fresh_next;
            latch_reg     <= latch_next;
            running_reg   <= running_next;
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            start_reg     <= start_next;
            thresh_reg    <= thresh_next;
            per_byte_reg  <= per_byte_next;
            valid_reg     <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            op_reg      <= op_t'(s_tuser[1:0]);
            is_read_reg <= s_tuser[2];
            data_reg    <= s_tdata[7:0];
            dist_reg    <= s_tdata[23:8];
            err_reg     <= s_tdata[27:24];
            unpl_reg    <= s_tdata[28];
        end
        if (fire) begin
            out_ack_reg <= out_ack_next;
            out_rd_reg  <= out_rd_next;
            out_irq_reg <= latch_next;
        end
    end

    // pointer byte count never passes two
    assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg != 2'd3)
        else $error("pointer byte count out of range");

    // a failed connect leaves pointer, byte count and latch untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && op_reg == OP_CONNECT && unpl_reg
        |=> $stable(ptr_reg) && $stable(seen_reg) && $stable(latch_reg))
        else $error("unplugged connect changed state");

    // while ranging, the tick count stays below the period
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> tick_reg < period_reg)
        else $error("tick count reached period while running");

    // the interrupt only rises as a result of a processed item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(latch_reg) |-> $past(fire))
        else $error("interrupt rose without an item");

    // a store write never targets the address read ahead
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ptr_next[STORE_AW-1:0] != ptr_reg[STORE_AW-1:0])
        else $error("store read-ahead collides with write");

endmodule

[test/tof_sensor_register_device_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the distance-sensor bus target: a directed table, then
// random bus transfers and tick bursts, checked against row answers or a shadow model.
// Depends on tsrd_pkg and the tof_sensor_register_device_unit RTL.

module tof_sensor_register_device_unit_test;
    import tsrd_pkg::*;

    localparam int RANDOM_ITEMS     = 400;
    localparam int MAX_REPORTS      = 10;
    localparam int LONG_HOLD        = 300;
    localparam int HOLD_AT_RESPONSE = 120;
    localparam int DRAIN_CYCLES     = 8;
    // limit well above the long receiver hold, which sets the longest quiet stretch in a good run
    localparam int STALL_LIMIT      = 2000;
    localparam int NUM_DIRECTED     = 25;

    typedef struct packed {
        op_t         op;
        logic        is_read;
        logic [7:0]  data_byte;
        logic [15:0] distance_mm;
        logic [3:0]  range_error;
        logic        unplugged;
    } bus_item_t;

    typedef struct packed {
        logic       ack;
        logic [7:0] read_data;
        logic       interrupt_pin;
    } response_t;

    typedef struct packed {
        bus_item_t item;
        logic      typed;
        response_t want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // shadow copy of the target's state
    logic [7:0]          shadow_regs [STORE_DEPTH];
    logic [15:0]         reg_ptr;
    logic [1:0]          ptr_bytes;
    logic [7:0]          fresh_byte;
    logic                irq_latch;
    logic                ranging_on;
    logic [PERIOD_W-1:0] tick_cnt;
    logic [PERIOD_W-1:0] ranging_len;

    response_t pending_responses [$];

    int  items_sent;
    int  directed_items;
    int  responses_checked;
    int  mismatch_count;
    int  interrupt_latches;
    int  ranging_periods;
    int  quiet_cycles;
    bit  send_no_gap;

    // directed table: only the rows with an obvious answer carry one
    row_t directed_rows [NUM_DIRECTED] = '{
        // connect while unplugged is not acknowledged
        '{'{OP_CONNECT, 1'b0, 8'h00, 16'h0000, 4'h0, 1'b1}, 1'b1, '{1'b0, 8'h00, 1'b0}},
        // read before any pointer: pointer still at the identity register
        '{'{OP_READ,    1'b0, 8'h00, 16'hFFFF, 4'hF, 1'b0}, 1'b1, '{1'b1, ID_VALUE, 1'b0}},
        // tick while stopped, unplugged flag ignored
        '{'{OP_TICK,    1'b1, 8'hFF, 16'h0000, 4'h0, 1'b1}, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{'{OP_READ,    1'b1, 8'h00, 16'h0000, 4'h5, 1'b1}, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{'{OP_CONNECT, 1'b0, 8'h00, 16'h0100, 4'h0, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{'{OP_WRITE,   1'b0, 8'h00, 16'h0000, 4'h0, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0}},
        // threshold 0x80, period byte 0
        '{'{OP_WRITE,   1'b0, 8'h1A, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h80, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        // start continuous ranging with a near target
        '{'{OP_CONNECT, 1'b0, 8'h00, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h00, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h18, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h02, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,    1'b0, 8'h00, 16'h0000, 4'h0, 1'b0}, 1'b0, '0},
        // clear the interrupt, then write the fresh flag
        '{'{OP_CONNECT, 1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h15, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'hFF, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        // pointer at the top of the space, read connect, wrap to zero
        '{'{OP_CONNECT, 1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'hFF, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,   1'b0, 8'hFF, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_CONNECT, 1'b1, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_READ,    1'b0, 8'h00, 16'hFFFF, 4'h0, 1'b0}, 1'b0, '0},
        '{'{OP_READ,    1'b0, 8'h00, 16'h0050, 4'h0, 1'b0}, 1'b0, '0}
    };

    tof_sensor_register_device_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // latch the interrupt when ranging is continuous and the target is near
    function automatic void evaluate_near(logic [7:0] dist_sat);
        logic [7:0] thr;
        thr = shadow_regs[ADDR_THRESH_LOW[STORE_AW-1:0]];
        if (shadow_regs[ADDR_RANGE_START[STORE_AW-1:0]][RANGE_CONT_BIT] && thr != 8'h00 &&
            dist_sat < thr) begin
            if (!irq_latch)
                interrupt_latches++;
            irq_latch = 1'b1;
        end
    endfunction

    // advance the shadow state by one bus item and return its response
    function automatic response_t predict_bus_response(bus_item_t it);
        response_t  r;
        logic [7:0] dist_sat;
        r = '{1'b1, 8'h00, 1'b0};
        dist_sat = (it.distance_mm > 16'd255) ? DIST_SAT : it.distance_mm[7:0];
        case (it.op)
            OP_CONNECT: begin
                if (it.unplugged)
                    r.ack = 1'b0;
                else if (!it.is_read)
                    ptr_bytes = 2'd0;
            end
            OP_WRITE: begin
                if (ptr_bytes == 2'd0) begin
                    reg_ptr = {it.data_byte, 8'h00};
                    ptr_bytes = 2'd1;
                end else if (ptr_bytes == 2'd1) begin
                    reg_ptr[7:0] = it.data_byte;
                    ptr_bytes = 2'd2;
                end else begin
                    if (reg_ptr == ADDR_FRESH)
                        fresh_byte = it.data_byte;
                    if (reg_ptr == ADDR_INT_CLEAR)
                        irq_latch = 1'b0;
                    if (reg_ptr < 16'(STORE_DEPTH))
                        shadow_regs[reg_ptr[STORE_AW-1:0]] = it.data_byte;
                    if (reg_ptr == ADDR_RANGE_START) begin
                        ranging_on = it.data_byte[RANGE_CONT_BIT];
                        if (ranging_on) begin
                            ranging_len = PERIOD_W'((int'(shadow_regs[ADDR_PERIOD[STORE_AW-1:0]])
                                                     + 1) * TICKS_PER_PERIOD_UNIT);
                            tick_cnt = '0;
                        end
                    end
                    reg_ptr = reg_ptr + 16'd1;
                    evaluate_near(dist_sat);
                end
            end
            OP_READ: begin
                case (reg_ptr)
                    ADDR_ID:           r.read_data = ID_VALUE;
                    ADDR_FRESH:        r.read_data = fresh_byte;
                    ADDR_INT_STATUS:   r.read_data = INT_STATUS_VALUE;
                    ADDR_RANGE_STATUS: r.read_data = {it.range_error, 4'h0};
                    ADDR_RANGE_VAL:    r.read_data = dist_sat;
                    ADDR_RETURN_RATE:  r.read_data = RETURN_RATE_VALUE;
                    default: begin
                        if (reg_ptr < 16'(STORE_DEPTH))
                            r.read_data = shadow_regs[reg_ptr[STORE_AW-1:0]];
                    end
                endcase
                reg_ptr = reg_ptr + 16'd1;
                evaluate_near(dist_sat);
            end
            default: begin
                // millisecond tick
                if (ranging_on) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= ranging_len) begin
                        tick_cnt = '0;
                        ranging_periods++;
                        evaluate_near(dist_sat);
                    end
                end
            end
        endcase
        r.interrupt_pin = irq_latch;
        return r;
    endfunction

    // bus item with random sensor inputs around the given bus fields
    function automatic bus_item_t make_item(op_t op, logic is_read, logic [7:0] data_byte);
        bus_item_t it;
        it.op = op;
        it.is_read = is_read;
        it.data_byte = data_byte;
        if ($urandom_range(0, 1) == 0)
            it.distance_mm = 16'($urandom_range(0, 300));
        else
            it.distance_mm = 16'($urandom_range(0, 65535));
        it.range_error = 4'($urandom_range(0, 15));
        it.unplugged = ($urandom_range(0, 19) == 0);
        return it;
    endfunction

    // register pointer biased toward the interesting parts of the map
    function automatic logic [15:0] pick_address();
        logic [15:0] addr;
        case ($urandom_range(0, 8))
            0: addr = ADDR_RANGE_START;
            1: addr = ADDR_THRESH_LOW;
            2: addr = ADDR_PERIOD;
            3: addr = ADDR_INT_CLEAR;
            4: begin
                case ($urandom_range(0, 5))
                    0: addr = ADDR_ID;
                    1: addr = ADDR_FRESH;
                    2: addr = ADDR_RANGE_STATUS;
                    3: addr = ADDR_INT_STATUS;
                    4: addr = ADDR_RANGE_VAL;
                    default: addr = ADDR_RETURN_RATE;
                endcase
            end
            5: addr = 16'($urandom_range(0, STORE_DEPTH - 1));
            6: addr = 16'($urandom_range(16'hFFFC, 16'hFFFF));
            7: addr = 16'($urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 3));
            default: addr = 16'($urandom_range(0, 65535));
        endcase
        return addr;
    endfunction

    // offer one item after a random gap and record its expected response
    task automatic send_item(bus_item_t it, logic typed, response_t want);
        int        gap;
        response_t predicted;
        if ($urandom_range(0, 29) == 0)
            send_no_gap = !send_no_gap;
        gap = send_no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, it.unplugged, it.range_error, it.distance_mm, it.data_byte};
        s_tuser <= {it.is_read, it.op};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_bus_response(it);
        pending_responses.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic note_failure(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at response %0d: %s expected 0x%0h got 0x%0h",
                     responses_checked, what, want, got);
    endtask

    // result side: random stalls, one long hold, field-by-field compare
    initial begin
        int        gap;
        bit        no_gap;
        bit        held;
        response_t want;
        response_t got;
        no_gap = 1'b0;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && responses_checked >= HOLD_AT_RESPONSE) begin
                gap = LONG_HOLD;
                held = 1'b1;
            end else begin
                if ($urandom_range(0, 29) == 0)
                    no_gap = !no_gap;
                gap = no_gap ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.ack = m_tdata[0];
            got.read_data = m_tdata[8:1];
            got.interrupt_pin = m_tdata[9];
            if (pending_responses.size() == 0) begin
                note_failure("response with nothing pending, m_tdata", 0, m_tdata);
            end else begin
                want = pending_responses.pop_front();
                if (got.ack !== want.ack)
                    note_failure("ack", want.ack, got.ack);
                if (got.read_data !== want.read_data)
                    note_failure("read_data", want.read_data, got.read_data);
                if (got.interrupt_pin !== want.interrupt_pin)
                    note_failure("interrupt_pin", want.interrupt_pin, got.interrupt_pin);
            end
            responses_checked++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses pending",
                     STALL_LIMIT, pending_responses.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        int          kind;
        int          count;
        bit          drained;
        logic [15:0] addr;
        logic [7:0]  wdata;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        aresetn <= 1'b0;
        send_no_gap = 1'b0;

        // shadow state after reset
        foreach (shadow_regs[i])
            shadow_regs[i] = 8'h00;
        reg_ptr = '0;
        ptr_bytes = '0;
        fresh_byte = FRESH_RESET;
        irq_latch = 1'b0;
        ranging_on = 1'b0;
        tick_cnt = '0;
        ranging_len = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        directed_items = items_sent;

        // random bus transfers, tick bursts and noise
        drained = 1'b0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            // halfway through, stop offering until every response is back
            if (!drained && items_sent >= directed_items + RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_responses.size() != 0);
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // write transfer: pointer, then a run of data bytes
                addr = pick_address();
                count = $urandom_range(1, 4);
                send_item(make_item(OP_CONNECT, 1'b0, 8'($urandom())), 1'b0, '0);
                send_item(make_item(OP_WRITE, 1'($urandom()), addr[15:8]), 1'b0, '0);
                send_item(make_item(OP_WRITE, 1'($urandom()), addr[7:0]), 1'b0, '0);
                repeat (count) begin
                    wdata = 8'($urandom_range(0, 255));
                    if (addr == ADDR_PERIOD && $urandom_range(0, 3) != 0)
                        wdata = 8'($urandom_range(0, 2));
                    if (addr == ADDR_RANGE_START && $urandom_range(0, 3) != 0)
                        wdata[RANGE_CONT_BIT] = 1'b1;
                    send_item(make_item(OP_WRITE, 1'($urandom()), wdata), 1'b0, '0);
                    addr = addr + 16'd1;
                end
            end else if (kind < 65) begin
                // read transfer: pointer, optional read connect, a run of reads
                addr = pick_address();
                count = $urandom_range(1, 4);
                send_item(make_item(OP_CONNECT, 1'b0, 8'($urandom())), 1'b0, '0);
                send_item(make_item(OP_WRITE, 1'($urandom()), addr[15:8]), 1'b0, '0);
                send_item(make_item(OP_WRITE, 1'($urandom()), addr[7:0]), 1'b0, '0);
                if ($urandom_range(0, 1) == 0)
                    send_item(make_item(OP_CONNECT, 1'b1, 8'($urandom())), 1'b0, '0);
                repeat (count)
                    send_item(make_item(OP_READ, 1'($urandom()), 8'($urandom())), 1'b0, '0);
            end else if (kind < 80) begin
                // tick burst, long enough to finish short ranging periods
                repeat ($urandom_range(1, 25))
                    send_item(make_item(OP_TICK, 1'($urandom()), 8'($urandom())), 1'b0, '0);
            end else begin
                // unstructured items
                repeat ($urandom_range(1, 4))
                    send_item(make_item(op_t'($urandom_range(0, 3)), 1'($urandom()),
                                        8'($urandom())), 1'b0, '0);
            end
        end

        // let the last responses drain
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d bus items (%0d from the directed table), %0d responses checked",
                 items_sent, directed_items, responses_checked);
        $display("run: %0d interrupt latches, %0d ranging periods completed, %0d mismatches",
                 interrupt_latches, ranging_periods, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
